// ===== design/gss_pkg.sv =====
package gss_pkg;

  localparam int GRID_SIZE   = 5;
  localparam int SEQ_DEPTH   = GRID_SIZE - 1;
  localparam int CELLS       = GRID_SIZE * GRID_SIZE;
  localparam int GRID_AW     = $clog2(CELLS);
  localparam int SEQ_AW      = $clog2(SEQ_DEPTH);
  localparam int WORD_W      = 32;
  localparam int COORD_W     = 3;
  localparam int SEQ_IDX_W   = 2;
  localparam int LEN_W       = 3;
  localparam int MODE_W      = 2;
  localparam int SEQ_LEN_MIN = 3;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_GRID_WR = 2'd0,
    MODE_SEQ_WR  = 2'd1,
    MODE_SEARCH  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    DIR_LR = 2'd0,
    DIR_RL = 2'd1,
    DIR_TB = 2'd2,
    DIR_BT = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    W_IDLE,
    W_SCAN,
    W_FINISH
  } walk_state_t;

  // One result handed from the walker to the output register
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    dir_t               dir;
    logic               last;
  } result_t;

  function automatic logic [GRID_AW-1:0] cell_addr(input logic [COORD_W-1:0] row,
                                                   input logic [COORD_W-1:0] col);
    logic [GRID_AW-1:0] base;
    base = GRID_AW'(row) * GRID_AW'(GRID_SIZE);
    return base + GRID_AW'(col);
  endfunction

endpackage

// ===== design/gss_ram.sv =====
module gss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/gss_walker.sv =====
module gss_walker
  import gss_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [LEN_W-1:0]    seq_len,
  input  logic                out_free,
  input  logic [WORD_W-1:0]   grid_rdata,
  input  logic [WORD_W-1:0]   seq_rdata,
  output logic                idle,
  output logic                grid_re,
  output logic [GRID_AW-1:0]  grid_raddr,
  output logic                seq_re,
  output logic [SEQ_AW-1:0]   seq_raddr,
  output result_t             push
);

  walk_state_t        state_r, state_nxt;
  logic               pass_r, pass_nxt;
  logic               rev_r, rev_nxt;
  logic [COORD_W-1:0] line_r, line_nxt;
  logic [COORD_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0]   t_r, t_nxt;
  logic               chk_r, chk_nxt;
  logic               chk_last_r, chk_last_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic [COORD_W-1:0] pend_row_r, pend_row_nxt;
  logic [COORD_W-1:0] pend_col_r, pend_col_nxt;
  dir_t               pend_dir_r, pend_dir_nxt;

  logic               issue;
  logic               match;
  logic               res_pass;
  logic               res_fail;
  logic               stall;
  logic               advance;
  logic [COORD_W-1:0] pos_end;
  logic [COORD_W-1:0] cell_pos;
  logic [COORD_W-1:0] far_pos;
  logic [COORD_W-1:0] anchor_pos;
  logic [LEN_W-1:0]   seq_pos;

  assign pos_end    = COORD_W'(GRID_SIZE) - COORD_W'(seq_len);
  assign cell_pos   = pos_r + COORD_W'(t_r);
  assign far_pos    = pos_r + COORD_W'(seq_len) - COORD_W'(1);
  assign anchor_pos = rev_r ? far_pos : pos_r;
  assign seq_pos    = rev_r ? (seq_len - LEN_W'(1) - t_r) : t_r;

  assign match    = (grid_rdata == seq_rdata);
  assign res_pass = chk_r && match && chk_last_r;
  assign res_fail = chk_r && !match;
  // A second match cannot park while the previous one still waits
  assign stall    = res_pass && pend_valid_r && !out_free;
  assign issue    = (state_r == W_SCAN) && (t_r < seq_len) && !stall;

  assign grid_re    = issue;
  assign grid_raddr = pass_r ? cell_addr(cell_pos, line_r) : cell_addr(line_r, cell_pos);
  assign seq_re     = issue;
  assign seq_raddr  = SEQ_AW'(seq_pos);
  assign idle       = (state_r == W_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= W_IDLE;
      chk_r        <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      chk_r        <= chk_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pass_r     <= pass_nxt;
    rev_r      <= rev_nxt;
    line_r     <= line_nxt;
    pos_r      <= pos_nxt;
    t_r        <= t_nxt;
    chk_last_r <= chk_last_nxt;
    pend_row_r <= pend_row_nxt;
    pend_col_r <= pend_col_nxt;
    pend_dir_r <= pend_dir_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    pass_nxt       = pass_r;
    rev_nxt        = rev_r;
    line_nxt       = line_r;
    pos_nxt        = pos_r;
    t_nxt          = t_r;
    chk_nxt        = chk_r;
    chk_last_nxt   = chk_last_r;
    pend_valid_nxt = pend_valid_r;
    pend_row_nxt   = pend_row_r;
    pend_col_nxt   = pend_col_r;
    pend_dir_nxt   = pend_dir_r;
    push           = '0;
    advance        = 1'b0;

    case (state_r)
      W_IDLE: begin
        if (start) begin
          state_nxt      = W_SCAN;
          pass_nxt       = 1'b0;
          rev_nxt        = 1'b0;
          line_nxt       = '0;
          pos_nxt        = '0;
          t_nxt          = '0;
          chk_nxt        = 1'b0;
          pend_valid_nxt = 1'b0;
        end
      end
      W_SCAN: begin
        if (!stall) begin
          if (issue) begin
            t_nxt        = t_r + LEN_W'(1);
            chk_nxt      = 1'b1;
            chk_last_nxt = (t_r == seq_len - LEN_W'(1));
          end else begin
            chk_nxt = 1'b0;
          end
          if (res_fail) begin
            // drop the read in flight and retry backward, or move on
            t_nxt   = '0;
            chk_nxt = 1'b0;
            if (!rev_r) begin
              rev_nxt = 1'b1;
            end else begin
              advance = 1'b1;
            end
          end else if (res_pass) begin
            t_nxt   = '0;
            chk_nxt = 1'b0;
            advance = 1'b1;
            if (pend_valid_r) begin
              push.valid = 1'b1;
              push.found = 1'b1;
              push.row   = pend_row_r;
              push.col   = pend_col_r;
              push.dir   = pend_dir_r;
              push.last  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_row_nxt   = pass_r ? anchor_pos : line_r;
            pend_col_nxt   = pass_r ? line_r : anchor_pos;
            pend_dir_nxt   = dir_t'({pass_r, rev_r});
          end
        end
        if (advance) begin
          rev_nxt = 1'b0;
          if (pos_r == pos_end) begin
            pos_nxt = '0;
            if (line_r == COORD_W'(GRID_SIZE - 1)) begin
              line_nxt = '0;
              if (pass_r) begin
                state_nxt = W_FINISH;
              end else begin
                pass_nxt = 1'b1;
              end
            end else begin
              line_nxt = line_r + COORD_W'(1);
            end
          end else begin
            pos_nxt = pos_r + COORD_W'(1);
          end
        end
      end
      W_FINISH: begin
        if (out_free) begin
          push.valid     = 1'b1;
          push.found     = pend_valid_r;
          push.row       = pend_valid_r ? pend_row_r : '0;
          push.col       = pend_valid_r ? pend_col_r : '0;
          push.dir       = pend_valid_r ? pend_dir_r : DIR_LR;
          push.last      = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = W_IDLE;
        end
      end
      default: begin
        state_nxt = W_IDLE;
      end
    endcase
  end

endmodule

// ===== design/grid_sequence_search.sv =====
// Four-direction sequence search over a GRID_SIZE x GRID_SIZE grid of 32-bit words.
//
// Input channel (in_*): one transfer per item. in_tuser carries the mode: grid
// write, sequence write or search. Writes land in the grid or sequence memory
// in the cycle of the transfer; out-of-range addresses are dropped. A search
// produces one result transfer per match on the out_* channel, rows first and
// then columns, with out_tlast on the final one. With no match a single
// not-found result (out_tuser low, zero payload) is sent with out_tlast set.
// Configuration: cfg_wr_en writes seq_len, saturated into 3..GRID_SIZE-1.
//
// Writes are taken back to back while no search runs. A search visits 2*GRID_SIZE*(GRID_SIZE-
// seq_len+1) start positions, one word compare per cycle through one read port per
// memory while no stall on a second match holds the walk: a forward test and, when it
// fails, a backward test. in_tready is low while a search runs. Each match is parked
// in a pending register until the next match or the end of the walk, so it can be
// tagged with tlast.
//
// Reset clears control state and sets seq_len to 3; memory contents are
// undefined until written. When the receiver stalls, the held result stays on
// out_* and the search pauses at its next match; input waits until the walk ends.
module grid_sequence_search
  import gss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // row[2:0], col[5:3], seq_index[7:6], value[39:8]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // mode[1:0]
  input  logic [MODE_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // match_row[2:0], match_col[5:3], direction[7:6]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // found[0]
  output logic                  out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_wr_en,
  input  logic [LEN_W-1:0]      cfg_wr_data
);

  logic [LEN_W-1:0]      seq_len_r, seq_len_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_found_r, out_found_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  in_xfer;
  logic [COORD_W-1:0]    in_row;
  logic [COORD_W-1:0]    in_col;
  logic [SEQ_IDX_W-1:0]  in_seq_idx;
  logic [WORD_W-1:0]     in_value;
  logic                  grid_we;
  logic                  seq_we;
  logic                  start;
  logic                  walk_idle;
  logic                  out_free;
  logic                  grid_re;
  logic [GRID_AW-1:0]    grid_raddr;
  logic [WORD_W-1:0]     grid_rdata;
  logic                  seq_re;
  logic [SEQ_AW-1:0]     seq_raddr;
  logic [WORD_W-1:0]     seq_rdata;
  result_t               push;

  assign in_row     = in_tdata[2:0];
  assign in_col     = in_tdata[5:3];
  assign in_seq_idx = in_tdata[7:6];
  assign in_value   = in_tdata[39:8];

  assign in_tready = walk_idle;
  assign in_xfer   = in_tvalid && in_tready;

  // Drop writes that fall outside the stores
  assign grid_we = in_xfer && (in_tuser == MODE_GRID_WR)
                   && ({1'b0, in_row} < (COORD_W + 1)'(GRID_SIZE))
                   && ({1'b0, in_col} < (COORD_W + 1)'(GRID_SIZE));
  assign seq_we  = in_xfer && (in_tuser == MODE_SEQ_WR)
                   && ({1'b0, in_seq_idx} < (SEQ_IDX_W + 1)'(SEQ_DEPTH));
  assign start   = in_xfer && (in_tuser == MODE_SEARCH);

  assign out_free = !out_valid_r || out_tready;

  gss_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_grid_ram (
    .clk     (clk),
    .wr_en   (grid_we),
    .wr_addr (cell_addr(in_row, in_col)),
    .wr_data (in_value),
    .rd_en   (grid_re),
    .rd_addr (grid_raddr),
    .rd_data (grid_rdata)
  );

  gss_ram #(.WIDTH(WORD_W), .DEPTH(SEQ_DEPTH)) u_seq_ram (
    .clk     (clk),
    .wr_en   (seq_we),
    .wr_addr (SEQ_AW'(in_seq_idx)),
    .wr_data (in_value),
    .rd_en   (seq_re),
    .rd_addr (seq_raddr),
    .rd_data (seq_rdata)
  );

  gss_walker u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .seq_len    (seq_len_r),
    .out_free   (out_free),
    .grid_rdata (grid_rdata),
    .seq_rdata  (seq_rdata),
    .idle       (walk_idle),
    .grid_re    (grid_re),
    .grid_raddr (grid_raddr),
    .seq_re     (seq_re),
    .seq_raddr  (seq_raddr),
    .push       (push)
  );

  // Saturate the written length into the legal window
  always_comb begin
    seq_len_nxt = seq_len_r;
    if (cfg_wr_en) begin
      if (cfg_wr_data < LEN_W'(SEQ_LEN_MIN)) begin
        seq_len_nxt = LEN_W'(SEQ_LEN_MIN);
      end else if (cfg_wr_data > LEN_W'(GRID_SIZE - 1)) begin
        seq_len_nxt = LEN_W'(GRID_SIZE - 1);
      end else begin
        seq_len_nxt = cfg_wr_data;
      end
    end
  end

  // Output register: load on push (only offered when free), clear on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;
    if (push.valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {push.dir, push.col, push.row};
      out_found_nxt = push.found;
      out_last_nxt  = push.last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r   <= LEN_W'(SEQ_LEN_MIN);
      out_valid_r <= 1'b0;
    end else begin
      seq_len_r   <= seq_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== design/gss_chk.sv =====
module gss_chk
  import gss_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [MODE_W-1:0]     in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser,
  input logic                  out_tlast
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // A not-found result closes its search and carries a zero payload
  a_miss_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && (out_tdata == '0))
    else $error("not-found result malformed");

  // A search holds off further input
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == MODE_SEARCH) |=> !in_tready)
    else $error("input taken during search");

  // Anchors stay on the grid
  a_anchor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_tdata[2:0]} < (COORD_W + 1)'(GRID_SIZE))
      && ({1'b0, out_tdata[5:3]} < (COORD_W + 1)'(GRID_SIZE)))
    else $error("anchor off grid");

endmodule

bind grid_sequence_search gss_chk u_gss_chk (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import gss_pkg::*;

  // Mode code with no operation behind it; the block must drop it silently
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int          ITEM_TARGET = 370;
  localparam int          IDLE_GUARD  = 8;     // settle time before a seq_len write
  localparam int          DRAIN_WAIT  = 40;    // watch for strays once all results are in
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // One search result as it appears on the output channel
  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    dir_t               dir;
    logic               last;
  } hit_t;

  // Shadow copy of the grid, the sequence and seq_len. Each accepted search
  // is expanded into its list of hits, which then waits for the output side.
  class search_scoreboard;
    logic [WORD_W-1:0] grid [GRID_SIZE][GRID_SIZE];
    logic [WORD_W-1:0] seq [SEQ_DEPTH];
    int                seq_len;
    hit_t              hits_due[$];
    int                errors;

    function new();
      seq_len = SEQ_LEN_MIN;
      errors  = 0;
    endfunction

    function void set_len(logic [LEN_W-1:0] v);
      if (int'(v) < SEQ_LEN_MIN) seq_len = SEQ_LEN_MIN;
      else if (int'(v) > GRID_SIZE - 1) seq_len = GRID_SIZE - 1;
      else seq_len = int'(v);
    endfunction

    function bit line_hit(int line, int pos, bit vertical, bit reverse);
      int                si;
      logic [WORD_W-1:0] w;
      for (int t = 0; t < seq_len; t++) begin
        si = reverse ? seq_len - 1 - t : t;
        w  = vertical ? grid[pos + t][line] : grid[line][pos + t];
        if (w !== seq[si]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_item(logic [MODE_W-1:0] mode, logic [COORD_W-1:0] row,
                            logic [COORD_W-1:0] col, logic [SEQ_IDX_W-1:0] sidx,
                            logic [WORD_W-1:0] value);
      hit_t hits[$];
      hit_t h;
      int   far;
      bit   vertical;
      case (mode)
        MODE_GRID_WR: begin
          if (int'(row) < GRID_SIZE && int'(col) < GRID_SIZE) grid[row][col] = value;
        end
        MODE_SEQ_WR: begin
          if (int'(sidx) < SEQ_DEPTH) seq[sidx] = value;
        end
        MODE_SEARCH: begin
          // rows first, then columns; backward only when forward fails
          for (int orient = 0; orient < 2; orient++) begin
            vertical = (orient == 1);
            for (int line = 0; line < GRID_SIZE; line++) begin
              for (int pos = 0; pos + seq_len <= GRID_SIZE; pos++) begin
                h       = '0;
                h.found = 1'b1;
                far     = pos + seq_len - 1;
                if (line_hit(line, pos, vertical, 1'b0)) begin
                  h.dir = vertical ? DIR_TB : DIR_LR;
                  h.row = COORD_W'(vertical ? pos : line);
                  h.col = COORD_W'(vertical ? line : pos);
                  hits.push_back(h);
                end else if (line_hit(line, pos, vertical, 1'b1)) begin
                  // backward hits are anchored at the far end of the run
                  h.dir = vertical ? DIR_BT : DIR_RL;
                  h.row = COORD_W'(vertical ? far : line);
                  h.col = COORD_W'(vertical ? line : far);
                  hits.push_back(h);
                end
              end
            end
          end
          if (hits.size() == 0) begin
            h = '0;
            hits.push_back(h);
          end
          hits[hits.size() - 1].last = 1'b1;
          foreach (hits[i]) hits_due.push_back(hits[i]);
        end
        default: ;
      endcase
    endfunction

    function void check_hit(hit_t act);
      hit_t exp;
      if (hits_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result found=%0d row=%0d col=%0d dir=%0d last=%0d",
                 $time, act.found, act.row, act.col, act.dir, act.last);
        return;
      end
      exp = hits_due.pop_front();
      if (act.found !== exp.found || act.row !== exp.row || act.col !== exp.col ||
          act.dir !== exp.dir || act.last !== exp.last) begin
        errors++;
        $display("%0t: expected found=%0d row=%0d col=%0d dir=%0d last=%0d, actual found=%0d row=%0d col=%0d dir=%0d last=%0d",
                 $time, exp.found, exp.row, exp.col, exp.dir, exp.last,
                 act.found, act.row, act.col, act.dir, act.last);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [MODE_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_wr_en = 1'b0;
  logic [LEN_W-1:0]      cfg_wr_data = '0;

  search_scoreboard  sb = new();
  hit_t              seen_hit;
  int                items_done = 0;
  int unsigned       cycle_count = 0;
  bit                steady = 1'b0;   // no gaps on the input side while set
  logic [WORD_W-1:0] symbols [4];
  int                nsym = 1;

  grid_sequence_search i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Output fields in the order of hit_t: found, row, col, direction, last
  assign seen_hit = {out_tuser, out_tdata[2:0], out_tdata[5:3], dir_t'(out_tdata[7:6]),
                     out_tlast};

  // Check every result transfer against the oldest predicted hit
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_hit(seen_hit);
  end

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("grid_sequence_search: mismatch");
      $finish;
    end
  end

  // Receiver back-pressure: long ready streaks, short stalls, a few long stalls
  initial begin
    int r;
    int n;
    @(posedge rst_n);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        out_tready = 1'b1;
        n = $urandom_range(50, 150);
      end else if (r < 50) begin
        out_tready = 1'b1;
        n = $urandom_range(1, 24);
      end else if (r < 88) begin
        out_tready = 1'b0;
        n = $urandom_range(1, 3);
      end else begin
        out_tready = 1'b0;
        n = $urandom_range(10, 40);
      end
      repeat (n) @(negedge clk);
    end
  end

  function automatic int in_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Mostly symbols from the small alphabet, so that matches are common
  function automatic logic [WORD_W-1:0] pick_value();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return symbols[$urandom_range(0, nsym - 1)];
  endfunction

  // Present one item at a falling edge and hold it until the transfer.
  // Valid stays high into the next call, so back-to-back items need no gap.
  task automatic send(input logic [MODE_W-1:0] mode, input logic [COORD_W-1:0] row,
                      input logic [COORD_W-1:0] col, input logic [SEQ_IDX_W-1:0] sidx,
                      input logic [WORD_W-1:0] value);
    int gap;
    gap = in_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = {value, sidx, col, row};
    do @(posedge clk); while (!in_tready);
    sb.note_item(mode, row, col, sidx, value);
    // ignored items do not count toward the stimulus total
    if (!(mode == MODE_UNUSED ||
          (mode == MODE_GRID_WR && (int'(row) >= GRID_SIZE || int'(col) >= GRID_SIZE))))
      items_done++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_cell(input int row, input int col, input logic [WORD_W-1:0] value);
    send(MODE_GRID_WR, COORD_W'(row), COORD_W'(col), SEQ_IDX_W'($urandom_range(0, 3)),
         value);
  endtask

  task automatic write_seq(input int idx, input logic [WORD_W-1:0] value);
    send(MODE_SEQ_WR, COORD_W'($urandom_range(0, 7)), COORD_W'($urandom_range(0, 7)),
         SEQ_IDX_W'(idx), value);
  endtask

  // Address and value fields are don't-care for a search; randomize them anyway
  task automatic search();
    send(MODE_SEARCH, COORD_W'($urandom_range(0, 7)), COORD_W'($urandom_range(0, 7)),
         SEQ_IDX_W'($urandom_range(0, 3)), $urandom());
  endtask

  // Lay the current sequence along one row or column, optionally reversed
  task automatic plant(input bit vertical, input int line, input int pos, input bit reverse);
    int si;
    for (int t = 0; t < sb.seq_len; t++) begin
      si = reverse ? sb.seq_len - 1 - t : t;
      if (vertical) write_cell(pos + t, line, sb.seq[si]);
      else write_cell(line, pos + t, sb.seq[si]);
    end
  endtask

  // Change seq_len only with the block idle: drain all results, then wait a bit
  task automatic write_len(input logic [LEN_W-1:0] v);
    release_input();
    while (sb.hits_due.size() != 0) @(posedge clk);
    repeat (IDLE_GUARD) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_len(v);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      write_cell($urandom_range(0, GRID_SIZE - 1), $urandom_range(0, GRID_SIZE - 1),
                 pick_value());
    end else if (r < 45) begin
      // out of range on at least one coordinate; must be dropped
      if ($urandom_range(0, 1))
        write_cell($urandom_range(GRID_SIZE, 7), $urandom_range(0, 7), $urandom());
      else
        write_cell($urandom_range(0, 7), $urandom_range(GRID_SIZE, 7), $urandom());
    end else if (r < 53) begin
      write_seq($urandom_range(0, SEQ_DEPTH - 1), pick_value());
    end else if (r < 65) begin
      plant($urandom_range(0, 1), $urandom_range(0, GRID_SIZE - 1),
            $urandom_range(0, GRID_SIZE - sb.seq_len), $urandom_range(0, 1));
    end else if (r < 70) begin
      send(MODE_UNUSED, COORD_W'($urandom_range(0, 7)), COORD_W'($urandom_range(0, 7)),
           SEQ_IDX_W'($urandom_range(0, 3)), $urandom());
    end else begin
      search();
    end
  endtask

  initial begin
    int phase;
    int len;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Preload: every cell and every sequence word is written before any search
    for (int r = 0; r < GRID_SIZE; r++)
      for (int c = 0; c < GRID_SIZE; c++) write_cell(r, c, $urandom());
    write_seq(0, 32'h8000_0000);
    write_seq(1, 32'h7FFF_FFFF);
    write_seq(2, 32'hFFFF_FFFF);
    write_seq(3, 32'h0000_0000);

    // Directed, seq_len still at its reset value of 3
    search();                 // random grid: not-found result
    plant(1'b0, 0, 0, 1'b0);  // forward along row 0
    search();
    plant(1'b1, 4, 2, 1'b1);  // backward up column 4, anchor at the bottom cell
    search();
    write_seq(2, 32'h8000_0000);  // palindrome: forward hit must suppress backward
    plant(1'b0, 2, 1, 1'b0);
    search();
    write_cell(GRID_SIZE, 0, 32'h0);  // dropped writes, then an unused mode
    write_cell(2, 7, 32'h0);
    write_cell(7, 7, $urandom());
    send(MODE_UNUSED, 3'd7, 3'd7, 2'd3, 32'hFFFF_FFFF);
    search();

    // Random phases, each with its own seq_len, alphabet and pacing
    phase = 0;
    while (items_done < ITEM_TARGET) begin
      case (phase)
        0: len = 0;
        1: len = 7;
        2: len = 4;
        3: len = 3;
        default: len = $urandom_range(0, 7);
      endcase
      write_len(LEN_W'(len));
      steady = ($urandom_range(0, 3) == 0);
      if (phase % 2 == 0) begin
        symbols[0] = 32'h0000_0000;
        symbols[1] = 32'hFFFF_FFFF;
        symbols[2] = 32'h8000_0000;
        symbols[3] = 32'h7FFF_FFFF;
      end else begin
        foreach (symbols[i]) symbols[i] = $urandom();
      end
      nsym = (phase == 1) ? 1 : $urandom_range(1, 3);
      for (int i = 0; i < SEQ_DEPTH; i++) write_seq(i, pick_value());
      // refill the whole grid now and then; a one-symbol fill makes hits common
      if (phase == 1 || $urandom_range(0, 3) == 0)
        for (int r = 0; r < GRID_SIZE; r++)
          for (int c = 0; c < GRID_SIZE; c++) write_cell(r, c, pick_value());
      repeat ($urandom_range(12, 24)) random_item();
      search();
      phase++;
    end

    release_input();
    while (sb.hits_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.hits_due.size() == 0) begin
      $display("grid_sequence_search: match");
    end else begin
      $display("grid_sequence_search: mismatch");
    end
    $finish;
  end

endmodule
